### hw/rtl/ctgr_pkg.sv
`timescale 1ns / 1ps

package ctgr_pkg;

   // Field widths of the request and response items
   localparam int OP_W    = 2;
   localparam int CODE_W  = 8;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 8;
   localparam int ROW_W   = 6;
   localparam int RADDR_W = 10;
   localparam int DATA_W  = 8;

   // Defaults for the top-level parameters
   localparam int FRAME_WIDTH_DEF = 128;
   localparam int FRAME_PAGES_DEF = 8;
   localparam int MAX_CHARS_DEF   = 21;

   // Glyph geometry
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int CELL_PITCH = 6;

   // Each glyph column touches up to two pages
   localparam int DRAW_SLOTS = 2 * GLYPH_COLS;
   localparam int SLOT_W     = $clog2(DRAW_SLOTS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] glyph_type;

   // 5x7 font, 7-bit columns with bit 0 at the top row; unknown codes are blank
   function automatic glyph_type glyph_lookup(input logic [CODE_W-1:0] code);
      glyph_type g;
      case (code)
         8'h30: g = '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}; // 0
         8'h31: g = '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00}; // 1
         8'h32: g = '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}; // 2
         8'h33: g = '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31}; // 3
         8'h34: g = '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}; // 4
         8'h35: g = '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39}; // 5
         8'h36: g = '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}; // 6
         8'h37: g = '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03}; // 7
         8'h38: g = '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}; // 8
         8'h39: g = '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}; // 9
         8'h41: g = '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}; // A
         8'h42: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36}; // B
         8'h43: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}; // C
         8'h44: g = '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C}; // D
         8'h45: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}; // E
         8'h46: g = '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01}; // F
         8'h47: g = '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}; // G
         8'h48: g = '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F}; // H
         8'h49: g = '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}; // I
         8'h4A: g = '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01}; // J
         8'h4B: g = '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}; // K
         8'h4C: g = '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40}; // L
         8'h4D: g = '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}; // M
         8'h4E: g = '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F}; // N
         8'h4F: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}; // O
         8'h50: g = '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06}; // P
         8'h51: g = '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}; // Q
         8'h52: g = '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46}; // R
         8'h53: g = '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}; // S
         8'h54: g = '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}; // T
         8'h55: g = '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}; // U
         8'h56: g = '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F}; // V
         8'h57: g = '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F}; // W
         8'h58: g = '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63}; // X
         8'h59: g = '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03}; // Y
         8'h5A: g = '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}; // Z
         8'h72: g = '{7'h7C, 7'h08, 7'h04, 7'h04, 7'h08}; // r
         8'h61: g = '{7'h20, 7'h54, 7'h54, 7'h54, 7'h78}; // a
         8'h69: g = '{7'h00, 7'h44, 7'h7D, 7'h40, 7'h00}; // i
         8'h6C: g = '{7'h00, 7'h41, 7'h7F, 7'h40, 7'h00}; // l
         8'h2D: g = '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08}; // -
         8'h3F: g = '{7'h02, 7'h01, 7'h51, 7'h09, 7'h06}; // ?
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

### hw/rtl/ctgr_req_if.sv
`timescale 1ns / 1ps

interface ctgr_req_if;
   logic                             valid;
   logic                             ready;
   logic [ctgr_pkg::OP_W-1:0]        op;
   logic [ctgr_pkg::CODE_W-1:0]      char_code;
   logic [ctgr_pkg::INDEX_W-1:0]     char_index;
   logic [ctgr_pkg::LEN_W-1:0]       line_length;
   logic [ctgr_pkg::ROW_W-1:0]       row_top;
   logic [ctgr_pkg::RADDR_W-1:0]     read_address;

   modport source (
      output valid, op, char_code, char_index, line_length, row_top, read_address,
      input  ready
   );

   modport sink (
      input  valid, op, char_code, char_index, line_length, row_top, read_address,
      output ready
   );
endinterface

### hw/rtl/ctgr_rsp_if.sv
`timescale 1ns / 1ps

interface ctgr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ctgr_pkg::DATA_W-1:0]   read_data;
   logic                          glyph_drawn;

   modport source (
      output valid, read_data, glyph_drawn,
      input  ready
   );

   modport sink (
      input  valid, read_data, glyph_drawn,
      output ready
   );
endinterface

### hw/rtl/ctgr_ram.sv
`timescale 1ns / 1ps

module ctgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/centered_text_glyph_renderer.sv
`timescale 1ns / 1ps

// From accept to result valid: a draw runs setup, then ten read-modify-write slots (five glyph
// columns on two pages each), skipped when the index is past the line end or limit; a read
// addresses the RAM, then captures the byte; a clear zeroes all FRAME_WIDTH*FRAME_PAGES bytes;
// an unused op goes straight to the result. One item is in work at a time; the next is taken
// once the result moves to the output register; the move waits while that register is full.
// Reset (synchronous) runs the same sweep with no result and holds requests off until it ends.
module centered_text_glyph_renderer #(
   parameter int FRAME_WIDTH = ctgr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_PAGES = ctgr_pkg::FRAME_PAGES_DEF,
   parameter int MAX_CHARS   = ctgr_pkg::MAX_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ctgr_req_if.sink   req_if,
   ctgr_rsp_if.source rsp_if
);

   import ctgr_pkg::*;

   localparam int STORE_SIZE = FRAME_WIDTH * FRAME_PAGES;
   localparam int AW         = $clog2(STORE_SIZE);
   // Wide enough for the centering offset plus the last cell of the longest line
   localparam int COL_W      = $clog2(FRAME_WIDTH + CELL_PITCH * MAX_CHARS + GLYPH_COLS);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DRAW  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RDCAP = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ptr_ff, clr_ptr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              wr_pend_ff, wr_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [RADDR_W-1:0] addr_ff, addr_in;
   logic [COL_W-1:0]   col_base_ff, col_base_in;
   glyph_type          glyph_ff, glyph_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [DATA_W-1:0]  wr_mask_ff, wr_mask_in;
   logic               drawn_ff, drawn_in;
   logic [DATA_W-1:0]  res_data_ff, res_data_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_drawn_ff, rsp_drawn_in;

   // Frame RAM ports
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   // Current draw slot: glyph column in the upper slot bits, lower/upper page in bit 0
   logic [SLOT_W-2:0]  slot_col;
   logic [15:0]        slot_shift;
   logic [DATA_W-1:0]  slot_byte;
   logic [3:0]         slot_page;
   logic [COL_W-1:0]   slot_x;
   logic [AW-1:0]      slot_addr;
   logic               slot_ok;

   logic req_fire;
   logic rsp_free;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.read_data   = rsp_data_ff;
   assign rsp_if.glyph_drawn = rsp_drawn_ff;

   // Slot decode: shift the glyph column down to the row inside its top page,
   // the spill-over lands in the next page
   always_comb begin
      slot_col   = slot_ff[SLOT_W-1:1];
      slot_shift = {9'd0, glyph_ff[slot_col]} << top_ff[2:0];
      slot_byte  = slot_ff[0] ? slot_shift[15:8] : slot_shift[7:0];
      slot_page  = {1'b0, top_ff[ROW_W-1:3]} + {3'd0, slot_ff[0]};
      slot_x     = col_base_ff + COL_W'(slot_col);
      slot_addr  = AW'(32'(slot_page) * FRAME_WIDTH + 32'(slot_x));
      // drop pixels off the right edge or below the last page; empty bytes are skipped too
      slot_ok    = (slot_byte != '0) && (32'(slot_x) < FRAME_WIDTH) &&
                   (32'(slot_page) < FRAME_PAGES);
   end

   // RAM access: the clearing sweep owns the write port; otherwise a pending
   // draw write ORs its mask into the byte read in the cycle before
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ptr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata | wr_mask_ff;
      end
      case (state_ff)
         ST_DRAW: ram_raddr = slot_addr;
         ST_READ: ram_raddr = AW'(32'(addr_ff));
         default: ram_raddr = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      logic [10:0] len_x6;
      logic [10:0] idx_x6;
      logic        len_fits;
      logic [COL_W-1:0] x0;

      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_rsp_in   = clr_rsp_ff;
      slot_in      = slot_ff;
      wr_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      code_in      = code_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      top_in       = top_ff;
      addr_in      = addr_ff;
      col_base_in  = col_base_ff;
      glyph_in     = glyph_ff;
      wr_addr_in   = slot_addr;
      wr_mask_in   = slot_byte;
      drawn_in     = drawn_ff;
      res_data_in  = res_data_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_drawn_in = rsp_drawn_ff;

      // line start: centered when the line fits, else flush left
      len_x6   = 11'(len_ff) * 11'(CELL_PITCH);
      idx_x6   = 11'(idx_ff) * 11'(CELL_PITCH);
      len_fits = (32'(len_ff) <= MAX_CHARS) && (32'(len_x6) <= FRAME_WIDTH);
      x0       = len_fits ? COL_W'((FRAME_WIDTH - 32'(len_x6)) >> 1) : '0;

      // drop the shown result once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_if.op;
               code_in     = req_if.char_code;
               idx_in      = req_if.char_index;
               len_in      = req_if.line_length;
               top_in      = req_if.row_top;
               addr_in     = req_if.read_address;
               res_data_in = '0;
               drawn_in    = 1'b0;
               case (req_if.op)
                  OP_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_ptr_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  OP_DRAW: state_in = ST_SETUP;
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == AW'(STORE_SIZE - 1)) begin
               // the sweep after reset gives no result
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SETUP: begin
            glyph_in    = glyph_lookup(code_ff);
            col_base_in = x0 + COL_W'(idx_x6);
            slot_in     = '0;
            // skip characters past the line end or past the line limit
            if ((idx_ff < len_ff) && (32'(idx_ff) < MAX_CHARS)) begin
               state_in = ST_DRAW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DRAW: begin
            // read this slot now, write it back next cycle
            wr_pend_in = slot_ok;
            drawn_in   = drawn_ff | slot_ok;
            slot_in    = slot_ff + SLOT_W'(1);
            if (slot_ff == SLOT_W'(DRAW_SLOTS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_RDCAP;
         end
         ST_RDCAP: begin
            // addresses past the store read as zero
            res_data_in = (32'(addr_ff) < STORE_SIZE) ? ram_rdata : '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_drawn_in = drawn_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers: reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         slot_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         slot_ff      <= slot_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      code_ff      <= code_in;
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      top_ff       <= top_in;
      addr_ff      <= addr_in;
      col_base_ff  <= col_base_in;
      glyph_ff     <= glyph_in;
      wr_addr_ff   <= wr_addr_in;
      wr_mask_ff   <= wr_mask_in;
      drawn_ff     <= drawn_in;
      res_data_ff  <= res_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_drawn_ff <= rsp_drawn_in;
   end

   ctgr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_SIZE)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
